[rtl/apd_pkg.sv]
// Shared types and constants for the all-pairs hop distance block.
// No dependencies; imported by apd_row_relax and all_pairs_hop_distance.
package apd_pkg;

    localparam int NODES_DEF  = 64;
    localparam int NODE_W     = 6;
    localparam int DIST_W     = 8;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int NCNT_W     = 7;

    localparam logic [DIST_W-1:0] UNREACH        = 8'd255;
    localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic [DIST_W-1:0] MAX_HOPS_RST   = 8'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_RELAX = 2'd2,
        REQ_QUERY = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_MAX_HOPS   = 1'b1
    } cfg_idx_t;

endpackage

[rtl/apd_row_relax.sv]
// One relaxation step over a whole matrix row: min(cur, left + pivot) per lane.
// Depends on apd_pkg for distance width and the unreachable code.
module apd_row_relax #(
    parameter int NODES = apd_pkg::NODES_DEF
) (
    input  logic [NODES-1:0][apd_pkg::DIST_W-1:0] pivot_row,
    input  logic [NODES-1:0][apd_pkg::DIST_W-1:0] cur_row,
    input  logic [apd_pkg::DIST_W-1:0]            left,
    input  logic [$clog2(NODES+1)-1:0]            n,
    output logic [NODES-1:0][apd_pkg::DIST_W-1:0] new_row,
    output logic [NODES-1:0]                      lane_en
);
    import apd_pkg::*;

    localparam int CNT_W = $clog2(NODES+1);

    for (genvar j = 0; j < NODES; j++) begin : g_lane
        logic [DIST_W:0]   sum;
        logic [DIST_W-1:0] sat;

        assign sum = {1'b0, left} + {1'b0, pivot_row[j]};
        // saturate at the unreachable code
        assign sat = sum[DIST_W] ? UNREACH : sum[DIST_W-1:0];
        assign new_row[j] = sat;
        assign lane_en[j] = (CNT_W'(j) < n) && (sat < cur_row[j]);
    end

endmodule

[rtl/all_pairs_hop_distance.sv]
// Top level of the all-pairs hop distance block: handshakes, config, sequencer
// and the row-wide distance matrix memory. Depends on apd_pkg, apd_row_relax.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   req     | in        | req_valid / req_stall  | req_type, node_a, node_b
//   res     | out       | res_valid / res_stall  | distance, reachable, done_res
//   cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One row of the NODES x NODES matrix is read and one written per cycle.
// Relaxation runs over n = min(node_count, NODES) pivots: each pivot row is read and
// loaded, then the n rows stream one row per cycle. Clear writes every row, an edge both
// entries in turn; the hand-off state then moves the item to the result register.
// After reset a clearing pass over all NODES rows runs before the first item is taken.
// A result waiting behind res_stall does not block the next item, only the next hand-off.
module all_pairs_hop_distance #(
    parameter int NODES = apd_pkg::NODES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [apd_pkg::REQ_W-1:0]        req_type,
    input  logic [apd_pkg::NODE_W-1:0]       node_a,
    input  logic [apd_pkg::NODE_W-1:0]       node_b,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [apd_pkg::DIST_W-1:0]       distance,
    output logic                             reachable,
    output logic                             done_res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [apd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import apd_pkg::*;

    localparam int ROW_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES+1);

    typedef logic [NODES-1:0][DIST_W-1:0] row_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_QUERY,
        ST_PIVOT_RD,
        ST_PIVOT_LD,
        ST_STREAM,
        ST_RESP
    } state_t;

    state_t              state_reg;
    logic [ROW_W-1:0]    row_cnt_reg;
    logic [ROW_W-1:0]    k_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [NODE_W-1:0]   a_reg;
    logic [NODE_W-1:0]   b_reg;
    logic                edge_ok_reg;
    logic [DIST_W-1:0]   pend_dist_reg;
    logic                pend_reach_reg;
    logic                pend_done_reg;
    logic                res_valid_reg;
    logic [DIST_W-1:0]   res_dist_reg;
    logic                res_reach_reg;
    logic                res_done_reg;
    logic [NCNT_W-1:0]   node_count_reg;
    logic [DIST_W-1:0]   max_hops_reg;

    row_t                mem [NODES];
    row_t                rd_data_reg;
    row_t                pivot_reg;

    logic                accept;
    logic [CNT_W-1:0]    n_in;
    logic [ROW_W-1:0]    a_row;
    logic [ROW_W-1:0]    b_row;
    logic                last_row;
    logic                last_k;
    logic                count_end;
    logic [DIST_W-1:0]   q_dist;
    row_t                clear_row;
    row_t                ones_row;
    row_t                relax_row;
    logic [NODES-1:0]    relax_lane;
    logic [DIST_W-1:0]   left;

    logic                wr_en;
    logic [ROW_W-1:0]    wr_row;
    logic [NODES-1:0]    wr_lane;
    row_t                wr_data;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_row;

    function automatic logic node_ok(input logic [NODE_W-1:0] v);
        return int'(v) < NODES;
    endfunction

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign res_valid = res_valid_reg;
    assign distance  = res_dist_reg;
    assign reachable = res_reach_reg;
    assign done_res  = res_done_reg;

    assign n_in  = (int'(node_count_reg) > NODES) ? CNT_W'(NODES) : CNT_W'(node_count_reg);
    assign a_row = ROW_W'(a_reg);
    assign b_row = ROW_W'(b_reg);

    assign last_row  = (CNT_W'(row_cnt_reg) + CNT_W'(1)) == n_reg;
    assign last_k    = (CNT_W'(k_reg) + CNT_W'(1)) == n_reg;
    assign count_end = (row_cnt_reg == ROW_W'(NODES-1));
    assign left      = rd_data_reg[k_reg];

    assign q_dist = (node_ok(a_reg) && node_ok(b_reg)) ? rd_data_reg[b_row] : UNREACH;

    always_comb
    begin
        for (int j = 0; j < NODES; j++)
        begin
            clear_row[j] = (ROW_W'(j) == row_cnt_reg) ? DIST_W'(0) : UNREACH;
            ones_row[j]  = DIST_W'(1);
        end
    end

    apd_row_relax #(
        .NODES     (NODES)
    ) u_relax (
        .pivot_row (pivot_reg),
        .cur_row   (rd_data_reg),
        .left      (left),
        .n         (n_reg),
        .new_row   (relax_row),
        .lane_en   (relax_lane)
    );

    // memory port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_row  = row_cnt_reg;
        wr_lane = '0;
        wr_data = clear_row;
        rd_en   = 1'b0;
        rd_row  = row_cnt_reg;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_lane = '1;
            end
            ST_EDGE_A:
            begin
                wr_en   = edge_ok_reg;
                wr_row  = a_row;
                wr_data = ones_row;
                for (int j = 0; j < NODES; j++)
                begin
                    wr_lane[j] = (ROW_W'(j) == b_row);
                end
            end
            ST_EDGE_B:
            begin
                wr_en   = edge_ok_reg;
                wr_row  = b_row;
                wr_data = ones_row;
                for (int j = 0; j < NODES; j++)
                begin
                    wr_lane[j] = (ROW_W'(j) == a_row);
                end
            end
            ST_IDLE:
            begin
                rd_en  = accept && (req_type == REQ_QUERY);
                rd_row = ROW_W'(node_a);
            end
            ST_PIVOT_RD:
            begin
                rd_en  = 1'b1;
                rd_row = k_reg;
            end
            ST_PIVOT_LD:
            begin
                rd_en  = 1'b1;
                rd_row = '0;
            end
            ST_STREAM:
            begin
                // write back row i while row i+1 is read; rows are independent within a pivot
                wr_en   = 1'b1;
                wr_lane = relax_lane;
                wr_data = relax_row;
                rd_en   = !last_row;
                rd_row  = row_cnt_reg + ROW_W'(1);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int j = 0; j < NODES; j++)
            begin
                if (wr_lane[j])
                begin
                    mem[wr_row][j] <= wr_data[j];
                end
            end
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
        if (state_reg == ST_PIVOT_LD)
        begin
            pivot_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            max_hops_reg   <= MAX_HOPS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_data[NCNT_W-1:0];
                CFG_MAX_HOPS:   max_hops_reg   <= cfg_data;
                default:        max_hops_reg   <= max_hops_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            row_cnt_reg    <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            edge_ok_reg    <= 1'b0;
            pend_dist_reg  <= '0;
            pend_reach_reg <= 1'b0;
            pend_done_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_dist_reg   <= '0;
            res_reach_reg  <= 1'b0;
            res_done_reg   <= 1'b0;
        end
        else
        begin
            // drop the item once taken, unless the hand-off state refills the register
            if (res_valid_reg && !res_stall && (state_reg != ST_RESP))
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT:
                begin
                    if (count_end)
                    begin
                        row_cnt_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        row_cnt_reg <= row_cnt_reg + ROW_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        a_reg          <= node_a;
                        b_reg          <= node_b;
                        edge_ok_reg    <= (node_a != node_b) && node_ok(node_a)
                                          && node_ok(node_b);
                        row_cnt_reg    <= '0;
                        k_reg          <= '0;
                        n_reg          <= n_in;
                        pend_dist_reg  <= '0;
                        pend_reach_reg <= 1'b0;
                        pend_done_reg  <= 1'b1;
                        case (req_type)
                            REQ_CLEAR: state_reg <= ST_CLEAR;
                            REQ_EDGE:  state_reg <= ST_EDGE_A;
                            REQ_RELAX: state_reg <= (n_in == '0) ? ST_RESP : ST_PIVOT_RD;
                            REQ_QUERY: state_reg <= ST_QUERY;
                            default:   state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_CLEAR:
                begin
                    if (count_end)
                    begin
                        row_cnt_reg <= '0;
                        state_reg   <= ST_RESP;
                    end
                    else
                    begin
                        row_cnt_reg <= row_cnt_reg + ROW_W'(1);
                    end
                end
                ST_EDGE_A:
                begin
                    state_reg <= ST_EDGE_B;
                end
                ST_EDGE_B:
                begin
                    state_reg <= ST_RESP;
                end
                ST_QUERY:
                begin
                    pend_dist_reg  <= q_dist;
                    pend_reach_reg <= (a_reg != b_reg) && (q_dist <= max_hops_reg);
                    pend_done_reg  <= 1'b0;
                    state_reg      <= ST_RESP;
                end
                ST_PIVOT_RD:
                begin
                    state_reg <= ST_PIVOT_LD;
                end
                ST_PIVOT_LD:
                begin
                    row_cnt_reg <= '0;
                    state_reg   <= ST_STREAM;
                end
                ST_STREAM:
                begin
                    if (last_row)
                    begin
                        if (last_k)
                        begin
                            state_reg <= ST_RESP;
                        end
                        else
                        begin
                            k_reg     <= k_reg + ROW_W'(1);
                            state_reg <= ST_PIVOT_RD;
                        end
                    end
                    else
                    begin
                        row_cnt_reg <= row_cnt_reg + ROW_W'(1);
                    end
                end
                ST_RESP:
                begin
                    // hold until the output register is free
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_valid_reg <= 1'b1;
                        res_dist_reg  <= pend_dist_reg;
                        res_reach_reg <= pend_reach_reg;
                        res_done_reg  <= pend_done_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_res_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_RESP))
        else $error("result appeared outside the hand-off state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("item taken while the previous one is still in work");

    a_stream_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM) |-> ((CNT_W'(row_cnt_reg) < n_reg) && (CNT_W'(k_reg) < n_reg)))
        else $error("relaxation row or pivot beyond node count");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_done_reg) |-> (res_dist_reg == '0 && !res_reach_reg))
        else $error("non-query item carries a distance");

endmodule

[test/testbench.sv]
// Self-checking testbench for all_pairs_hop_distance: directed table, then random
// graph sequences under several register settings. Depends on apd_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import apd_pkg::*;

    localparam int NODES = NODES_DEF;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              reach;
        logic              done;
    } reply_t;

    typedef struct packed {
        req_t              rq;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic              typed;
        logic [DIST_W-1:0] hop_cnt;
        logic              reach;
        logic              done;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req_type = REQ_CLEAR;
    logic [NODE_W-1:0]     node_a = '0;
    logic [NODE_W-1:0]     node_b = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [DIST_W-1:0]     distance;
    logic                  reachable;
    logic                  done_res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_NODE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the block: distance matrix and both registers
    logic [DIST_W-1:0] hop_mat [NODES][NODES];
    logic [NCNT_W-1:0] node_count_m;
    logic [DIST_W-1:0] max_hops_m;

    reply_t reply_q [$];
    int     err_cnt = 0;
    int     issued = 0;
    bit     quiet = 1'b0;

    // Directed walk at the reset settings: node_count 64, max_hops 1
    step_t plan [0:21] = '{
        '{REQ_QUERY, 6'd0,  6'd1,  1'b1, 8'd255, 1'b0, 1'b0},
        '{REQ_QUERY, 6'd63, 6'd63, 1'b1, 8'd0,   1'b0, 1'b0},
        '{REQ_QUERY, 6'd0,  6'd0,  1'b1, 8'd0,   1'b0, 1'b0},
        '{REQ_EDGE,  6'd0,  6'd1,  1'b1, 8'd0,   1'b0, 1'b1},
        '{REQ_EDGE,  6'd5,  6'd5,  1'b1, 8'd0,   1'b0, 1'b1},
        '{REQ_QUERY, 6'd5,  6'd5,  1'b1, 8'd0,   1'b0, 1'b0},
        '{REQ_QUERY, 6'd1,  6'd0,  1'b1, 8'd1,   1'b1, 1'b0},
        '{REQ_EDGE,  6'd1,  6'd2,  1'b1, 8'd0,   1'b0, 1'b1},
        '{REQ_EDGE,  6'd62, 6'd63, 1'b1, 8'd0,   1'b0, 1'b1},
        '{REQ_EDGE,  6'd63, 6'd0,  1'b1, 8'd0,   1'b0, 1'b1},
        '{REQ_QUERY, 6'd0,  6'd2,  1'b1, 8'd255, 1'b0, 1'b0},
        '{REQ_RELAX, 6'd0,  6'd0,  1'b1, 8'd0,   1'b0, 1'b1},
        '{REQ_QUERY, 6'd0,  6'd2,  1'b0, 8'd0,   1'b0, 1'b0},
        '{REQ_QUERY, 6'd62, 6'd2,  1'b0, 8'd0,   1'b0, 1'b0},
        '{REQ_QUERY, 6'd2,  6'd62, 1'b0, 8'd0,   1'b0, 1'b0},
        '{REQ_QUERY, 6'd63, 6'd1,  1'b0, 8'd0,   1'b0, 1'b0},
        '{REQ_QUERY, 6'd42, 6'd21, 1'b1, 8'd255, 1'b0, 1'b0},
        '{REQ_CLEAR, 6'd0,  6'd0,  1'b1, 8'd0,   1'b0, 1'b1},
        '{REQ_QUERY, 6'd0,  6'd1,  1'b1, 8'd255, 1'b0, 1'b0},
        '{REQ_QUERY, 6'd63, 6'd0,  1'b1, 8'd255, 1'b0, 1'b0},
        '{REQ_EDGE,  6'd21, 6'd42, 1'b1, 8'd0,   1'b0, 1'b1},
        '{REQ_QUERY, 6'd42, 6'd21, 1'b1, 8'd1,   1'b1, 1'b0}
    };

    all_pairs_hop_distance u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .node_a    (node_a),
        .node_b    (node_b),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .distance  (distance),
        .reachable (reachable),
        .done_res  (done_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic clear_mat();
        for (int i = 0; i < NODES; i++)
            for (int j = 0; j < NODES; j++)
                hop_mat[i][j] = (i == j) ? 8'd0 : UNREACH;
    endtask

    task automatic relax_mat();
        int n;
        int sum;
        n = (int'(node_count_m) > NODES) ? NODES : int'(node_count_m);
        for (int via = 0; via < n; via++)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                begin
                    sum = int'(hop_mat[i][via]) + int'(hop_mat[via][j]);
                    if (sum > int'(UNREACH))
                        sum = int'(UNREACH);
                    if (sum < int'(hop_mat[i][j]))
                        hop_mat[i][j] = DIST_W'(sum);
                end
    endtask

    // Update the mirror for one request and return the reply it should give
    task automatic apply_request(input req_t rq, input logic [NODE_W-1:0] a,
                                 input logic [NODE_W-1:0] b, output reply_t r);
        r = '{distance: '0, reach: 1'b0, done: 1'b1};
        case (rq)
            REQ_CLEAR: clear_mat();
            REQ_EDGE:
                if (a != b && int'(a) < NODES && int'(b) < NODES)
                begin
                    hop_mat[a][b] = 8'd1;
                    hop_mat[b][a] = 8'd1;
                end
            REQ_RELAX: relax_mat();
            default:
            begin
                r.done = 1'b0;
                r.distance = (int'(a) < NODES && int'(b) < NODES) ? hop_mat[a][b] : UNREACH;
                r.reach = (a != b) && (r.distance <= max_hops_m);
            end
        endcase
    endtask

    task automatic flag_error(input string field, input int got, input int want);
        $display("ERROR %0t: %s got %0d want %0d", $time, field, got, want);
        err_cnt++;
    endtask

    task automatic send_req(input req_t rq, input logic [NODE_W-1:0] a,
                            input logic [NODE_W-1:0] b, input bit typed, input reply_t want);
        reply_t r;
        int gap;
        apply_request(rq, a, b, r);
        reply_q.insert(reply_q.size(), typed ? want : r);
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= rq;
        node_a <= a;
        node_b <= b;
        do @(posedge clk); while (req_stall);
        issued++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_config(input logic [CFG_DATA_W-1:0] nc_data,
                              input logic [CFG_DATA_W-1:0] hops);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NODE_COUNT;
        cfg_data <= nc_data;
        do @(posedge clk); while (!cfg_ready);
        node_count_m = nc_data[NCNT_W-1:0];
        cfg_index <= CFG_MAX_HOPS;
        cfg_data <= hops;
        do @(posedge clk); while (!cfg_ready);
        max_hops_m = hops;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [NODE_W-1:0] pick_node(input int span);
        if ($urandom_range(0, 9) == 0)
            return NODE_W'($urandom_range(0, NODES - 1));
        return NODE_W'($urandom_range(0, span - 1));
    endfunction

    // Build a graph, relax it, then ask about it; some noise mixed in
    task automatic random_phase();
        int span;
        int cnt;
        span = (int'(node_count_m) > NODES) ? NODES : int'(node_count_m);
        if (span < 2)
            span = 4;
        quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) != 0)
            send_req(REQ_CLEAR, pick_node(span), pick_node(span), 1'b0, '0);
        cnt = $urandom_range(1, span + 2);
        repeat (cnt) send_req(REQ_EDGE, pick_node(span), pick_node(span), 1'b0, '0);
        if ($urandom_range(0, 4) == 0)
            send_req(req_t'($urandom_range(0, 3)), NODE_W'($urandom),
                     NODE_W'($urandom), 1'b0, '0);
        send_req(REQ_RELAX, pick_node(span), pick_node(span), 1'b0, '0);
        cnt = $urandom_range(3, 8);
        repeat (cnt) send_req(REQ_QUERY, pick_node(span), pick_node(span), 1'b0, '0);
        if ($urandom_range(0, 4) == 0)
            send_req(req_t'($urandom_range(0, 3)), NODE_W'($urandom),
                     NODE_W'($urandom), 1'b0, '0);
    endtask

    // Result side: stall for a drawn number of cycles, then take one item
    initial
    begin
        int hold;
        reply_t exp_r;
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                res_stall <= 1'b0;
            end
            do @(posedge clk); while (!res_valid);
            if (reply_q.size() == 0)
                flag_error("unexpected item, distance", int'(distance), 0);
            else
            begin
                exp_r = reply_q.pop_front();
                if (distance !== exp_r.distance)
                    flag_error("distance", int'(distance), int'(exp_r.distance));
                if (reachable !== exp_r.reach)
                    flag_error("reachable", int'(reachable), int'(exp_r.reach));
                if (done_res !== exp_r.done)
                    flag_error("done_res", int'(done_res), int'(exp_r.done));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("all_pairs_hop_distance verification failed");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] nc_data;
        logic [CFG_DATA_W-1:0] hops;
        clear_mat();
        node_count_m = NODE_COUNT_RST;
        max_hops_m = MAX_HOPS_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
            send_req(plan[k].rq, plan[k].a, plan[k].b, plan[k].typed,
                     '{distance: plan[k].hop_cnt, reach: plan[k].reach, done: plan[k].done});

        // Extremes: zero nodes (bit 7 set), one node, above NODES, full size
        set_config(8'h80, 8'd255);
        random_phase();
        set_config(8'd1, 8'd0);
        random_phase();
        set_config(8'h7F, 8'd255);
        random_phase();
        set_config(8'd64, 8'd2);
        random_phase();

        while (issued < 132)
        begin
            nc_data = {1'($urandom), 7'($urandom_range(2, 12))};
            if ($urandom_range(0, 7) == 0)
                nc_data[NCNT_W-1:0] = 7'($urandom_range(13, 64));
            hops = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6)) : 8'($urandom);
            set_config(nc_data, hops);
            random_phase();
        end

        drain();
        repeat (16) @(posedge clk);
        if (err_cnt == 0)
            $display("all_pairs_hop_distance verification clean");
        else
            $display("all_pairs_hop_distance verification failed");
        $finish;
    end

endmodule

[all_pairs_hop_distance.f]
rtl/apd_pkg.sv
rtl/apd_row_relax.sv
rtl/all_pairs_hop_distance.sv
test/testbench.sv
